// ===== hw/rtl/ferr_pkg.sv =====
`default_nettype none

package ferr_pkg;

    localparam int DEFAULT_DEPTH_WORDS = 1024;
    localparam int RESET_RING_WORDS    = 1024;

    localparam int WORD_W      = 11;
    localparam int OFFS_W      = 10;
    localparam int TYPE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int HDR_W       = TYPE_W + WORD_W;

    localparam logic [TYPE_W-1:0] RESET_MARKER = 8'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RING_WORDS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER     = 1'd1;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] record_words;
        logic [TYPE_W-1:0] record_type;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFS_W-1:0]   record_offset;
        logic                wrapped;
        logic [WORD_W-1:0]   evicted_count;
        logic [WORD_W-1:0]   used_words;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/ferr_ram.sv =====
`default_nettype none

module ferr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/frame_evicting_record_ring.sv =====
// A ring reset or a rejected item gives its result in the cycle after acceptance.
// An allocation that needs no eviction passes the tail, fit and place states first.
// Each evicted record adds a header read and an eviction step, and after a lone record
// or a marker's frame the tail and fit states run again. Results cannot be stalled.
// Resets and rejected items can be taken every cycle while idle; allocations keep busy high.
// Synchronous reset empties the ring and restores the defaults; header memory is kept.
`default_nettype none

module frame_evicting_record_ring #(
    parameter int RING_DEPTH_WORDS = ferr_pkg::DEFAULT_DEPTH_WORDS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire ferr_pkg::t_cmd                      i_cmd,
    input  wire logic                                i_cfg_we,
    input  wire logic [ferr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [ferr_pkg::WORD_W-1:0]         i_cfg_wdata,
    output logic                                     busy,
    output logic                                     o_result_valid,
    output ferr_pkg::t_result                        o_result
);

    import ferr_pkg::*;

    localparam int ADDR_W     = $clog2(RING_DEPTH_WORDS);
    localparam int RESET_RING = (RESET_RING_WORDS < RING_DEPTH_WORDS) ?
                                RESET_RING_WORDS : RING_DEPTH_WORDS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TAIL   = 3'd1;
    localparam logic [2:0] S_FIT    = 3'd2;
    localparam logic [2:0] S_EV_RD  = 3'd3;
    localparam logic [2:0] S_EV_USE = 3'd4;
    localparam logic [2:0] S_PLACE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [WORD_W-1:0] r_ring_words, n_ring_words;
    logic [TYPE_W-1:0] r_marker, n_marker;
    logic [WORD_W-1:0] r_oldest, n_oldest;
    logic [WORD_W-1:0] r_used, n_used;
    logic [WORD_W-1:0] r_live, n_live;
    logic [WORD_W-1:0] r_tail, n_tail;
    logic [WORD_W-1:0] r_size, n_size;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [WORD_W-1:0] r_evicted, n_evicted;
    logic              r_in_frame, n_in_frame;
    logic              r_result_valid, n_result_valid;
    t_result           r_result, n_result;

    logic [WORD_W-1:0] cfg_ring;
    logic [WORD_W:0]   tail_sum;
    logic [WORD_W:0]   tail_wrap;
    logic [WORD_W-1:0] free_words;
    logic [WORD_W-1:0] tail_gap;
    logic              fit_now;
    logic [HDR_W-1:0]  rd_hdr;
    logic [TYPE_W-1:0] rd_type;
    logic [WORD_W-1:0] rd_size;
    logic [WORD_W-1:0] ev_sz;
    logic [WORD_W:0]   ev_sum;
    logic [WORD_W-1:0] ev_used;
    logic [WORD_W-1:0] tail_room;
    logic [WORD_W-1:0] place_offset;
    logic              place_wrap;
    logic              ram_wr_en;
    logic              ram_rd_en;

    ferr_ram #(
        .WIDTH (HDR_W),
        .DEPTH (RING_DEPTH_WORDS)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ADDR_W'(place_offset)),
        .i_wr_data ({r_type, r_size}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ADDR_W'(r_oldest)),
        .o_rd_data (rd_hdr)
    );

    assign rd_type   = rd_hdr[HDR_W-1:WORD_W];
    assign rd_size   = rd_hdr[WORD_W-1:0];
    assign ram_wr_en = (r_state == S_PLACE);
    assign ram_rd_en = (r_state == S_FIT) || (r_state == S_EV_RD);

    always_comb begin
        cfg_ring = i_cfg_wdata;
        if (cfg_ring == '0) begin
            cfg_ring = WORD_W'(1);
        end
        if (32'(cfg_ring) > 32'(RING_DEPTH_WORDS)) begin
            cfg_ring = WORD_W'(RING_DEPTH_WORDS);
        end
    end

    always_comb begin
        tail_sum  = {1'b0, r_oldest} + {1'b0, r_used};
        tail_wrap = tail_sum - {1'b0, r_live};
    end

    always_comb begin
        tail_gap   = r_ring_words - r_tail;
        free_words = '0;
        fit_now    = 1'b0;
        if (r_oldest > r_tail) begin
            free_words = r_oldest - r_tail;
        end else if (r_oldest == r_tail) begin
            fit_now = (r_used == '0);
        end else begin
            free_words = (tail_gap > r_oldest) ? tail_gap : r_oldest;
        end
        if (free_words >= r_size) begin
            fit_now = 1'b1;
        end
    end

    always_comb begin
        ev_sz = rd_size;
        if ((rd_size == '0) || (rd_size > r_used)) begin
            ev_sz = r_used;
        end
        ev_sum  = {1'b0, r_oldest} + {1'b0, ev_sz};
        ev_used = r_used - ev_sz;
    end

    always_comb begin
        tail_room    = (r_live > r_tail) ? (r_live - r_tail) : '0;
        place_wrap   = (tail_room < r_size);
        place_offset = place_wrap ? '0 : r_tail;
    end

    always_comb begin
        n_state        = r_state;
        n_ring_words   = r_ring_words;
        n_marker       = r_marker;
        n_oldest       = r_oldest;
        n_used         = r_used;
        n_live         = r_live;
        n_tail         = r_tail;
        n_size         = r_size;
        n_type         = r_type;
        n_evicted      = r_evicted;
        n_in_frame     = r_in_frame;
        n_result_valid = 1'b0;
        n_result       = r_result;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RING_WORDS: begin
                    n_ring_words = cfg_ring;
                    n_oldest     = '0;
                    n_used       = '0;
                    n_live       = cfg_ring;
                end
                CFG_MARKER: begin
                    n_marker = i_cfg_wdata[TYPE_W-1:0];
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_size    = i_cmd.record_words;
                    n_type    = i_cmd.record_type;
                    n_evicted = '0;
                    n_result  = '0;
                    if (i_cmd.operation == OP_CLEAR) begin
                        n_oldest       = '0;
                        n_used         = '0;
                        n_live         = r_ring_words;
                        n_result_valid = 1'b1;
                    end else if (i_cmd.record_type == '0) begin
                        n_result.status     = ST_BAD_TYPE;
                        n_result.used_words = r_used;
                        n_result_valid      = 1'b1;
                    end else if ((i_cmd.record_words == '0) ||
                                 (i_cmd.record_words > r_ring_words)) begin
                        n_result.status     = ST_BAD_SIZE;
                        n_result.used_words = r_used;
                        n_result_valid      = 1'b1;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                n_tail  = (tail_sum >= {1'b0, r_live}) ? tail_wrap[WORD_W-1:0] :
                                                         tail_sum[WORD_W-1:0];
                n_state = S_FIT;
            end
            S_FIT: begin
                n_in_frame = 1'b0;
                n_state    = fit_now ? S_PLACE : S_EV_USE;
            end
            S_EV_RD: begin
                n_state = S_EV_USE;
            end
            S_EV_USE: begin
                if (r_in_frame && (rd_type == r_marker)) begin
                    n_in_frame = 1'b0;
                    n_state    = S_TAIL;
                end else begin
                    n_evicted = r_evicted + WORD_W'(1);
                    n_used    = ev_used;
                    if ((ev_used == '0) || (ev_sum >= {1'b0, r_live})) begin
                        n_oldest = '0;
                        n_live   = r_ring_words;
                    end else begin
                        n_oldest = ev_sum[WORD_W-1:0];
                    end
                    if ((r_in_frame || (rd_type == r_marker)) && (ev_used != '0)) begin
                        n_in_frame = 1'b1;
                        n_state    = S_EV_RD;
                    end else begin
                        n_in_frame = 1'b0;
                        n_state    = S_TAIL;
                    end
                end
            end
            S_PLACE: begin
                if (place_wrap) begin
                    n_live = r_ring_words - tail_room;
                end
                n_used                 = r_used + r_size;
                n_result.status        = ST_OK;
                n_result.record_offset = place_offset[OFFS_W-1:0];
                n_result.wrapped       = place_wrap;
                n_result.evicted_count = r_evicted;
                n_result.used_words    = r_used + r_size;
                n_result_valid         = 1'b1;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ring_words   <= WORD_W'(RESET_RING);
            r_marker       <= RESET_MARKER;
            r_oldest       <= '0;
            r_used         <= '0;
            r_live         <= WORD_W'(RESET_RING);
            r_in_frame     <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_ring_words   <= n_ring_words;
            r_marker       <= n_marker;
            r_oldest       <= n_oldest;
            r_used         <= n_used;
            r_live         <= n_live;
            r_in_frame     <= n_in_frame;
            r_result_valid <= n_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail    <= n_tail;
        r_size    <= n_size;
        r_type    <= n_type;
        r_evicted <= n_evicted;
        r_result  <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

`ifndef NO_ASSERTIONS
    a_used_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_ring_words)
        else $error("occupancy exceeds ring size");

    a_live_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_ring_words)
        else $error("live size exceeds ring size");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted item neither started nor answered");

    a_place_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |=> (o_result_valid && !busy))
        else $error("placement did not give a result");
`endif

endmodule

`default_nettype wire

// ===== verif/ring_check_pkg.sv =====
`timescale 1ns / 1ps

package ring_check_pkg;
    import ferr_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH_WORDS;
    localparam int MAX_REPORTS = 10;
    localparam logic [TYPE_W-1:0] INVALID_TYPE = '0;

    class ring_alloc_checker;
        bit [TYPE_W-1:0] hdr_type [DEPTH];
        int unsigned hdr_size [DEPTH];
        int unsigned oldest;
        int unsigned used;
        int unsigned live;
        int unsigned ring_size;
        int unsigned marker;
        t_result pending_results [$];
        int unsigned mismatches;
        int unsigned unexpected;
        int unsigned checked;
        int unsigned items;
        int unsigned evictions;
        int unsigned wraps;
        int unsigned rejects;
        int unsigned clears;

        function new();
            ring_size = RESET_RING_WORDS;
            marker = RESET_MARKER;
            empty_ring();
        endfunction

        function void empty_ring();
            oldest = 0;
            used = 0;
            live = ring_size;
        endfunction

        function int unsigned tail_offset();
            int unsigned e;
            e = oldest + used;
            if (e >= live) begin
                e -= live;
            end
            return e;
        endfunction

        function void write_config(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
            int unsigned v;
            if (idx == CFG_RING_WORDS) begin
                v = value & 32'h7FF;
                if (v == 0) begin
                    v = 1;
                end
                if (v > DEPTH) begin
                    v = DEPTH;
                end
                ring_size = v;
                empty_ring();
            end else if (idx == CFG_MARKER) begin
                marker = value & 32'hFF;
            end
        endfunction

        function void evict_one();
            int unsigned sz;
            sz = hdr_size[oldest % DEPTH];
            if (sz == 0 || sz > used) begin
                sz = used;
            end
            oldest += sz;
            if (oldest >= live) begin
                oldest = 0;
                live = ring_size;
            end
            used -= sz;
            if (used == 0) begin
                empty_ring();
            end
        endfunction

        // A marker record takes the whole frame behind it; anything else goes alone.
        function int unsigned evict_frame();
            int unsigned n;
            n = 0;
            if (hdr_type[oldest % DEPTH] == marker) begin
                do begin
                    evict_one();
                    n++;
                end while (used > 0 && hdr_type[oldest % DEPTH] != marker);
            end else begin
                evict_one();
                n++;
            end
            return n;
        endfunction

        function t_result predict_allocation(t_cmd c);
            t_result r;
            int unsigned size;
            int unsigned e;
            int unsigned free_words;
            int unsigned gap;
            int unsigned room;
            int unsigned evicted;
            int unsigned offset;
            r = '0;
            size = c.record_words;
            evicted = 0;
            offset = 0;
            if (c.operation == OP_CLEAR) begin
                empty_ring();
                clears++;
            end else if (c.record_type == INVALID_TYPE) begin
                r.status = ST_BAD_TYPE;
                rejects++;
            end else if (size == 0 || size > ring_size) begin
                r.status = ST_BAD_SIZE;
                rejects++;
            end else begin
                while (1) begin
                    e = tail_offset();
                    free_words = 0;
                    if (oldest > e) begin
                        free_words = oldest - e;
                    end else if (oldest == e) begin
                        if (used == 0) begin
                            break;
                        end
                    end else begin
                        gap = ring_size - e;
                        free_words = (gap > oldest) ? gap : oldest;
                    end
                    if (free_words >= size) begin
                        break;
                    end
                    evicted += evict_frame();
                end
                e = tail_offset();
                room = (live > e) ? live - e : 0;
                if (room >= size) begin
                    offset = e;
                end else begin
                    offset = 0;
                    r.wrapped = 1'b1;
                    live = ring_size - room;
                    wraps++;
                end
                used += size;
                hdr_type[offset % DEPTH] = c.record_type;
                hdr_size[offset % DEPTH] = size;
                evictions += evicted;
            end
            r.record_offset = OFFS_W'(offset);
            r.evicted_count = WORD_W'(evicted);
            r.used_words = WORD_W'(used);
            return r;
        endfunction

        function void note_command(t_cmd c);
            items++;
            pending_results.push_back(predict_allocation(c));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches + unexpected <= MAX_REPORTS) begin
                    $display("Mismatch on %s of result %0d: expected %0d, got %0d",
                             name, checked, want, got);
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS) begin
                    $display("Result with no item waiting: status %0d offset %0d used %0d",
                             got.status, got.record_offset, got.used_words);
                end
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("record_offset", 16'(want.record_offset), 16'(got.record_offset));
            compare_field("wrapped", 16'(want.wrapped), 16'(got.wrapped));
            compare_field("evicted_count", 16'(want.evicted_count), 16'(got.evicted_count));
            compare_field("used_words", 16'(want.used_words), 16'(got.used_words));
        endfunction

        function int unsigned failures();
            return mismatches + unexpected + pending_results.size();
        endfunction
    endclass

endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ferr_pkg::*;
    import ring_check_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int MAX_GAP = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_FIELD = 2047;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_cmd i_cmd = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0] i_cfg_wdata = '0;
    logic busy;
    logic o_result_valid;
    t_result o_result;

    ring_alloc_checker ring_model;
    int unsigned cycle_count = 0;
    int unsigned settings_used = 1;
    bit no_gaps = 1'b0;

    always #1 i_clk = ~i_clk;

    frame_evicting_record_ring DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_cmd(i_cmd),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .busy(busy),
        .o_result_valid(o_result_valid),
        .o_result(o_result)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL frame_evicting_record_ring");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            ring_model.check_result(o_result);
        end
    end

    function automatic t_cmd make_cmd(logic op, int unsigned words, int unsigned rtype);
        t_cmd c;
        c.operation = op;
        c.record_words = WORD_W'(words);
        c.record_type = TYPE_W'(rtype);
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        int unsigned pick;
        int unsigned ring;
        int unsigned words;
        int unsigned rtype;
        ring = ring_model.ring_size;
        pick = $urandom_range(0, 99);
        if (ring_model.marker != 0 && $urandom_range(0, 3) == 0) begin
            rtype = ring_model.marker;
        end else begin
            rtype = $urandom_range(1, 255);
        end
        if (pick < 4) begin
            return make_cmd(OP_CLEAR, $urandom_range(0, MAX_FIELD), $urandom_range(0, 255));
        end else if (pick < 7) begin
            return make_cmd(OP_ALLOC, $urandom_range(0, MAX_FIELD), INVALID_TYPE);
        end else if (pick < 10) begin
            words = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(ring + 1, MAX_FIELD);
        end else if (pick < 75) begin
            words = $urandom_range(1, (ring >= 8) ? ring / 8 : 1);
        end else if (pick < 95) begin
            words = $urandom_range(1, ring);
        end else begin
            words = $urandom_range(ring - ring / 2, ring);
        end
        return make_cmd(OP_ALLOC, words, rtype);
    endfunction

    task automatic send_cmd(input t_cmd c);
        int unsigned gap;
        bit taken;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = (busy === 1'b0);
        end
        ring_model.note_command(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (ring_model.pending_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_ring(input int unsigned ring_val, input int unsigned marker_val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_RING_WORDS;
        i_cfg_wdata <= WORD_W'(ring_val);
        @(posedge i_clk);
        i_cfg_index <= CFG_MARKER;
        i_cfg_wdata <= WORD_W'(marker_val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ring_model.write_config(CFG_RING_WORDS, ring_val);
        ring_model.write_config(CFG_MARKER, marker_val);
        settings_used++;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned ring_val, input int unsigned marker_val,
                             input int unsigned count);
        drain();
        program_ring(ring_val, marker_val);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            send_cmd(random_cmd());
        end
    endtask

    initial begin
        t_cmd directed [$];
        ring_model = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default ring: a clear and errors first, then a full ring, frames, a wrap, a clear and refill.
        directed = '{
            make_cmd(OP_CLEAR, MAX_FIELD, 255),
            make_cmd(OP_ALLOC, 5, INVALID_TYPE),
            make_cmd(OP_ALLOC, 0, INVALID_TYPE),
            make_cmd(OP_ALLOC, 0, 7),
            make_cmd(OP_ALLOC, 1025, 7),
            make_cmd(OP_ALLOC, MAX_FIELD, 255),
            make_cmd(OP_ALLOC, 1024, 1),
            make_cmd(OP_ALLOC, 1, 128),
            make_cmd(OP_ALLOC, 500, 2),
            make_cmd(OP_ALLOC, 300, 1),
            make_cmd(OP_ALLOC, 100, 3),
            make_cmd(OP_ALLOC, 100, 4),
            make_cmd(OP_ALLOC, 200, 5),
            make_cmd(OP_ALLOC, 400, 6),
            make_cmd(OP_ALLOC, 1024, 170),
            make_cmd(OP_ALLOC, 512, 1),
            make_cmd(OP_ALLOC, 256, 85),
            make_cmd(OP_ALLOC, 256, 1),
            make_cmd(OP_ALLOC, 600, 2),
            make_cmd(OP_CLEAR, 0, 0),
            make_cmd(OP_ALLOC, 1, 255),
            make_cmd(OP_ALLOC, 1023, 1),
            make_cmd(OP_ALLOC, 2, 2)
        };
        foreach (directed[i]) begin
            send_cmd(directed[i]);
        end

        run_phase(0, 0, 120);
        run_phase(MAX_FIELD, MAX_FIELD, 220);
        run_phase(7, 3, 200);
        run_phase(64, 1, 250);
        run_phase(300, 200, 220);
        run_phase(1024, 1, 250);
        run_phase($urandom_range(2, 1024), $urandom_range(0, 255), 267);
        drain();

        $display("Ran %0d items (%0d rejected, %0d ring clears) over %0d register settings.",
                 ring_model.items, ring_model.rejects, ring_model.clears, settings_used);
        $display("Checked %0d results: %0d records evicted, %0d placements wrapped.",
                 ring_model.checked, ring_model.evictions, ring_model.wraps);
        if (ring_model.failures() == 0) begin
            $display("PASS frame_evicting_record_ring");
        end else begin
            $display("FAIL frame_evicting_record_ring");
        end
        $finish;
    end

endmodule

// ===== frame_evicting_record_ring.f =====
hw/rtl/ferr_pkg.sv
hw/rtl/ferr_ram.sv
hw/rtl/frame_evicting_record_ring.sv
verif/ring_check_pkg.sv
verif/testbench.sv
